// ===== rtl/b7s_pkg.sv =====
// Shared constants, types and the segment glyph table of the seven-segment digit block.
package b7s_pkg;

    localparam int VALUE_W       = 16;
    localparam int DIGIT_W       = 4;
    localparam int SEG_W         = 8;
    localparam int SHOWN_DIGITS  = 4;
    localparam int DIGIT_COUNT_DEF = 4;

    typedef logic [VALUE_W-1:0] t_value;
    typedef logic [DIGIT_W-1:0] t_digit;
    typedef logic [SEG_W-1:0]   t_seg;

    // Active-low code with every segment and the decimal point dark.
    localparam t_seg BLANK_CODE = 8'hFF;

    // Active-low segment code: bit 0 is segment a, bit 6 is segment g, bit 7 the point.
    function automatic t_seg glyph(input t_digit digit);
        t_seg code;
        unique case (digit)
            4'h0: code = 8'hC0;
            4'h1: code = 8'hF9;
            4'h2: code = 8'hA4;
            4'h3: code = 8'hB0;
            4'h4: code = 8'h99;
            4'h5: code = 8'h92;
            4'h6: code = 8'h82;
            4'h7: code = 8'hF8;
            4'h8: code = 8'h80;
            4'h9: code = 8'h98;
            4'hA: code = 8'h88;
            4'hB: code = 8'h83;
            4'hC: code = 8'hC6;
            4'hD: code = 8'hA1;
            4'hE: code = 8'h86;
            4'hF: code = 8'h8E;
            default: code = BLANK_CODE;
        endcase
        return code;
    endfunction

endpackage

// ===== rtl/b7s_digits.sv =====
// Splits a 16-bit value into decimal or hexadecimal digits and flags values that do not fit.
module b7s_digits
    import b7s_pkg::*;
#(
    parameter int DIGIT_COUNT = DIGIT_COUNT_DEF
) (
    input  t_value                     i_value,
    input  logic                       i_hex_mode,
    output t_digit [DIGIT_COUNT-1:0]   o_digits,
    output logic                       o_overflow
);

    localparam logic [63:0] DEC_LIMIT = 64'(10 ** DIGIT_COUNT);
    localparam logic [63:0] HEX_LIMIT = (DIGIT_COUNT * DIGIT_W >= 64) ? '1 :
                                        (64'd1 << (DIGIT_COUNT * DIGIT_W));

    // Quotients of the value by successive powers of ten, one reciprocal multiply each.
    t_value [DIGIT_COUNT:0] w_quot;

    genvar k;
    generate
        for (k = 0; k <= DIGIT_COUNT; k++) begin : g_quot
            localparam logic [63:0] DIV   = 64'(10 ** k);
            localparam int          LOG_D = $clog2(DIV);
            localparam int          SHIFT = VALUE_W + LOG_D;
            localparam logic [63:0] MAGIC = ((64'd1 << SHIFT) + DIV - 64'd1) / DIV;
            localparam int          PROD_W = 2 * VALUE_W + 1;

            logic [PROD_W-1:0] w_prod;

            assign w_prod      = PROD_W'(i_value) * PROD_W'(MAGIC[VALUE_W:0]);
            assign w_quot[k]   = VALUE_W'(w_prod >> SHIFT);
        end

        for (k = 0; k < DIGIT_COUNT; k++) begin : g_digit
            t_value w_rem;
            t_digit w_hex;

            // Remainder of one quotient after taking ten times the next one away.
            assign w_rem = w_quot[k] - ((w_quot[k+1] << 3) + (w_quot[k+1] << 1));

            if (DIGIT_W * k < VALUE_W) begin : g_hex_bits
                assign w_hex = i_value[DIGIT_W*k +: DIGIT_W];
            end else begin : g_hex_zero
                assign w_hex = '0;
            end

            assign o_digits[k] = i_hex_mode ? w_hex : w_rem[DIGIT_W-1:0];
        end
    endgenerate

    assign o_overflow = i_hex_mode ? ({48'd0, i_value} >= HEX_LIMIT)
                                   : ({48'd0, i_value} >= DEC_LIMIT);

endmodule

// ===== rtl/binary_to_seven_segment_digits.sv =====
// Top level of the seven-segment digit block: handshakes, held codes and result register.
//
// The block takes one 16-bit unsigned value per item and shows it on DIGIT_COUNT
// seven-segment digits, in decimal or in hexadecimal as the hex_mode register selects
// (write it through the configuration channel while the block is idle; reset selects
// decimal). Leading zeros are shown as zero. Segment codes are active low, bit 0 is
// segment a through bit 6 segment g, bit 7 the decimal point. The digit codes are held
// between items: when a value does not fit in DIGIT_COUNT digits (decimal values of
// 10000 and up with four digits), the held codes stay as they were and the result
// carries overflow set. After reset every digit is blank. Each item yields exactly one
// result. The block is a two-stage pipeline, an input register followed by the digit
// split, glyph lookup and result register, so it takes a new item every cycle while
// the output is not stalled; an accepted item moves from the input register into the
// result register once that is empty or its result is taken. The rate is set by the one
// reciprocal multiply per power of ten, which fits between the two registers. Outputs
// beyond DIGIT_COUNT read blank, digits beyond the four outputs are held but not shown.
module binary_to_seven_segment_digits
    import b7s_pkg::*;
#(
    parameter int DIGIT_COUNT = DIGIT_COUNT_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,

    input  logic   i_cfg_valid,
    output logic   o_cfg_ready,
    input  logic   i_cfg_data,

    input  logic   i_valid,
    output logic   o_stall,
    input  t_value i_value,

    output logic   o_valid,
    input  logic   i_stall,
    output t_seg   o_seg_ones,
    output t_seg   o_seg_tens,
    output t_seg   o_seg_hundreds,
    output t_seg   o_seg_thousands,
    output logic   o_overflow
);

    logic                     r_hex_mode;
    logic                     r_in_valid, n_in_valid;
    t_value                   r_value;
    logic                     r_out_valid, n_out_valid;
    logic                     r_overflow;
    t_seg [DIGIT_COUNT-1:0]   r_held;

    t_digit [DIGIT_COUNT-1:0] w_digits;
    logic                     w_over;
    logic                     w_advance;
    logic                     w_load;
    logic                     w_take;
    t_seg [SHOWN_DIGITS-1:0]  w_shown;

    // The configuration register can always be written.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hex_mode <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_hex_mode <= i_cfg_data;
        end
    end

    // The result register may load when it is empty or its item is taken this cycle.
    // The input register then moves forward, so an item can be accepted every cycle.
    assign w_advance = !r_out_valid || !i_stall;
    assign w_load    = r_in_valid && w_advance;
    assign o_stall   = r_in_valid && !w_advance;
    assign w_take    = i_valid && !o_stall;

    assign n_in_valid  = w_take || (r_in_valid && !w_advance);
    assign n_out_valid = w_load || (r_out_valid && i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_value <= i_value;
        end
    end

    b7s_digits #(
        .DIGIT_COUNT (DIGIT_COUNT)
    ) u_digits (
        .i_value     (r_value),
        .i_hex_mode  (r_hex_mode),
        .o_digits    (w_digits),
        .o_overflow  (w_over)
    );

    // The held codes double as the result payload. They change only when a new
    // item loads into the result register, and keep their old value on overflow.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= {DIGIT_COUNT{BLANK_CODE}};
        end else if (w_load && !w_over) begin
            for (int i = 0; i < DIGIT_COUNT; i++) begin
                r_held[i] <= glyph(w_digits[i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_overflow <= w_over;
        end
    end

    genvar k;
    generate
        for (k = 0; k < SHOWN_DIGITS; k++) begin : g_shown
            if (k < DIGIT_COUNT) begin : g_held
                assign w_shown[k] = r_held[k];
            end else begin : g_blank
                assign w_shown[k] = BLANK_CODE;
            end
        end
    endgenerate

    assign o_valid         = r_out_valid;
    assign o_seg_ones      = w_shown[0];
    assign o_seg_tens      = w_shown[1];
    assign o_seg_hundreds  = w_shown[2];
    assign o_seg_thousands = w_shown[3];
    assign o_overflow      = r_overflow;

    // An item that does not fit leaves the held codes untouched.
    a_overflow_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load && w_over |=> $stable(r_held))
        else $error("held codes changed on an overflowing item");

    // Back pressure reaches the input only while the input register holds an item.
    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> !o_stall)
        else $error("input stalled with an empty input register");

    // With four or more hexadecimal digits every 16-bit value fits.
    a_hex_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load && r_hex_mode && (DIGIT_COUNT >= SHOWN_DIGITS) |-> !w_over)
        else $error("overflow flagged for a hexadecimal value");

endmodule
